// ----- sv/assert_macros.svh -----
// Assertion macros used by the checker file czacc_chk.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define CZ_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define CZ_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- sv/czacc_pkg.sv -----
// Package for the COM-ZMP acceleration core: widths, codes, constants.
// No dependencies; imported by czacc_front, the core top and czacc_chk.
`timescale 1ns / 1ps

package czacc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int POS_W     = 32;
  localparam int D_W       = POS_W + 1;
  localparam int NRM_W     = 18;
  localparam int MASS_W    = 31;
  localparam int THR_W     = 16;
  localparam int PD_W      = NRM_W + D_W;
  localparam int PF_W      = NRM_W + POS_W;
  localparam int H_W       = PD_W + 2;
  localparam int N_W       = PF_W + 2;
  localparam int HSPLIT    = (H_W - 1) / 2;
  localparam int DEN_W     = MASS_W + H_W - 1;
  localparam int SQ_W      = 31;
  localparam int ROOT_W    = 24;
  localparam int EQ_W      = POS_W + FRAC_BITS;
  localparam int PROD_W    = 64;
  localparam int ACC_W     = EQ_W + 3;
  localparam int LAT_FRONT = 5;
  localparam int CFG_IDX_W = 3;

  localparam longint GRAV_Q = ((64'd980665 << FRAC_BITS) + 64'd50000) / 64'd100000;

  typedef enum logic [1:0] {
    STAT_OK   = 2'd0,
    STAT_LOW  = 2'd1,
    STAT_PULL = 2'd2
  } status_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MASS = 3'd0,
    CFG_NX   = 3'd1,
    CFG_NY   = 3'd2,
    CFG_NZ   = 3'd3,
    CFG_TINY = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    status_t            status;
    logic [DEN_W-1:0]   den;
    logic [DEN_W-1:0]   rem0;
  } front_out_t;

  // a zero mass register reads as one LSB
  function automatic logic [MASS_W-1:0] eff_mass(input logic [MASS_W-1:0] m);
    eff_mass = (m == '0) ? MASS_W'(1) : m;
  endfunction

endpackage

// ----- sv/czacc_dly.sv -----
// Delay line that carries a word alongside the pipeline.
// Depends on nothing; stages advance with the pipeline enable.
`timescale 1ns / 1ps

module czacc_dly #(
  parameter int W = 1,
  parameter int D = 1
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  generate
    if (D == 0) begin : g_pass
      assign dout = din;
    end else begin : g_line
      logic [W-1:0] tap [D];
      always_ff @(posedge clk) begin
        if (en) begin
          tap[0] <= din;
          for (int k = 1; k < D; k++) begin
            tap[k] <= tap[k-1];
          end
        end
      end
      assign dout = tap[D-1];
    end
  endgenerate

endmodule

// ----- sv/czacc_front.sv -----
// Front end: differences, dot products with the normal, checks, divisor.
// Depends on czacc_pkg; five register stages.
`timescale 1ns / 1ps

module czacc_front
  import czacc_pkg::*;
(
  input  logic                     clk,
  input  logic                     en,
  input  logic signed [POS_W-1:0]  com [3],
  input  logic signed [POS_W-1:0]  zmp [3],
  input  logic signed [POS_W-1:0]  frc [3],
  input  logic [MASS_W-1:0]        body_mass,
  input  logic signed [NRM_W-1:0]  nrm [3],
  input  logic [THR_W-1:0]         tiny_threshold,
  output logic signed [D_W-1:0]    d [3],
  output front_out_t               fo
);

  logic signed [POS_W-1:0]  f1 [3];
  logic signed [PD_W-1:0]   pd [3];
  logic signed [PF_W-1:0]   pf [3];
  logic signed [H_W-1:0]    h3;
  logic signed [N_W-1:0]    n3;
  logic signed [H_W-1:0]    thr_q;
  logic [MASS_W-1:0]        m_eff;
  logic [MASS_W+HSPLIT-1:0] mh_lo;
  logic [MASS_W+HSPLIT-1:0] mh_hi;
  logic signed [N_W-1:0]    n4;
  status_t                  st4;
  status_t                  st4_next;

  assign thr_q = H_W'({tiny_threshold, {FRAC_BITS{1'b0}}});
  assign m_eff = eff_mass(body_mass);

  // height check wins over the force check
  always_comb begin
    if (h3 <= thr_q) begin
      st4_next = STAT_LOW;
    end else if (n3 < 0) begin
      st4_next = STAT_PULL;
    end else begin
      st4_next = STAT_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d[i]  <= D_W'(com[i]) - D_W'(zmp[i]);
        f1[i] <= frc[i];
        pd[i] <= PD_W'(nrm[i]) * PD_W'(d[i]);
        pf[i] <= PF_W'(nrm[i]) * PF_W'(f1[i]);
      end
      h3 <= H_W'(pd[0]) + H_W'(pd[1]) + H_W'(pd[2]);
      n3 <= N_W'(pf[0]) + N_W'(pf[1]) + N_W'(pf[2]);
      // split m*h into two narrow products; h is positive whenever it matters
      mh_lo <= (MASS_W+HSPLIT)'(m_eff) * (MASS_W+HSPLIT)'(h3[HSPLIT-1:0]);
      mh_hi <= (MASS_W+HSPLIT)'(m_eff) * (MASS_W+HSPLIT)'(h3[2*HSPLIT-1:HSPLIT]);
      n4    <= n3;
      st4   <= st4_next;
      fo.den    <= DEN_W'(mh_lo) + DEN_W'({mh_hi, {HSPLIT{1'b0}}});
      fo.rem0   <= DEN_W'(n4[N_W-2:0]) << (2 * FRAC_BITS - SQ_W);
      fo.status <= st4;
    end
  end

endmodule

// ----- sv/czacc_div.sv -----
// Pipelined restoring divider, one quotient bit per register stage.
// Depends on nothing; the overflow flag marks rem0 >= den at entry.
`timescale 1ns / 1ps

module czacc_div #(
  parameter int DW = 31,
  parameter int QW = 48
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] rem0,
  input  logic [QW-1:0] lo,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          ovf
);

  logic [DW-1:0] rr  [QW+1];
  logic [QW-1:0] qq  [QW+1];
  logic [QW-1:0] ll  [QW+1];
  logic [DW-1:0] dd  [QW+1];
  logic          oo  [QW+1];

  assign rr[0] = rem0;
  assign qq[0] = '0;
  assign ll[0] = lo;
  assign dd[0] = den;
  assign oo[0] = (rem0 >= den);

  generate
    for (genvar k = 0; k < QW; k++) begin : g_step
      logic [DW:0] sh;
      logic        ge;
      assign sh = {rr[k], ll[k][QW-1-k]};
      assign ge = (sh >= {1'b0, dd[k]});
      always_ff @(posedge clk) begin
        if (en) begin
          rr[k+1] <= ge ? DW'(sh - {1'b0, dd[k]}) : DW'(sh);
          qq[k+1] <= {qq[k][QW-2:0], ge};
          ll[k+1] <= ll[k];
          dd[k+1] <= dd[k];
          oo[k+1] <= oo[k];
        end
      end
    end
  endgenerate

  assign quo = qq[QW];
  assign ovf = oo[QW];

endmodule

// ----- sv/czacc_sqrt.sv -----
// Pipelined integer square root, one root bit per register stage.
// Depends on nothing; root = floor(sqrt(x)).
`timescale 1ns / 1ps

module czacc_sqrt #(
  parameter int RW = 24
) (
  input  logic            clk,
  input  logic            en,
  input  logic [2*RW-1:0] x,
  output logic [RW-1:0]   root
);

  logic [RW:0]     rem [RW+1];
  logic [RW-1:0]   rt  [RW+1];
  logic [2*RW-1:0] xx  [RW+1];

  assign rem[0] = '0;
  assign rt[0]  = '0;
  assign xx[0]  = x;

  generate
    for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RW+2:0] sh;
      logic [RW+2:0] trial;
      logic          ge;
      assign sh    = {rem[k], xx[k][2*RW-1-2*k -: 2]};
      assign trial = (RW+3)'({rt[k], 2'b01});
      assign ge    = (sh >= trial);
      always_ff @(posedge clk) begin
        if (en) begin
          rem[k+1] <= ge ? (RW+1)'(sh - trial) : (RW+1)'(sh);
          rt[k+1]  <= {rt[k][RW-2:0], ge};
          xx[k+1]  <= xx[k];
        end
      end
    end
  endgenerate

  assign root = rt[RW];

endmodule

// ----- sv/com_zmp_acceleration_core.sv -----
// COM-ZMP acceleration core: one word in, one word out, fully pipelined.
// Accepts one word per cycle while the output is not stalled.
// The 31-step zeta divider and the 24-step square root set the depth.
// A stalled output freezes the whole pipeline; nothing is lost or repeated.
// Synchronous reset clears the valid bits and loads the register defaults.
`timescale 1ns / 1ps

module com_zmp_acceleration_core
  import czacc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // com_x, com_y, com_z, zmp_x, zmp_y, zmp_z, force_x, force_y, force_z,
  // ext_force_x, ext_force_y, ext_force_z (32 bits each)
  input  logic [12*POS_W-1:0]  s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // acc_x, acc_y, acc_z (32 each), zeta_squared (31), zeta_root (24), pad (1)
  output logic [151:0]         m_tdata,
  // status
  output logic [1:0]           m_tuser,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [MASS_W-1:0]    cfg_data
);

  localparam int T_S     = LAT_FRONT + SQ_W + 1;
  localparam int T_PROD  = T_S + 1;
  localparam int T_EXTQ  = EQ_W;
  localparam int T_ACC   = ((T_PROD > T_EXTQ) ? T_PROD : T_EXTQ) + 1;
  localparam int T_ROOT  = T_S + ROOT_W;
  localparam int T_OUT   = (T_ROOT > T_ACC) ? T_ROOT : T_ACC;

  logic en;
  logic [T_OUT-1:0] vld;

  logic [MASS_W-1:0]       body_mass;
  logic signed [NRM_W-1:0] nrm [3];
  logic [THR_W-1:0]        tiny_threshold;

  logic signed [POS_W-1:0] com [3];
  logic signed [POS_W-1:0] zmp [3];
  logic signed [POS_W-1:0] frc [3];
  logic signed [POS_W-1:0] ext [3];
  logic [POS_W-1:0]        ext_mag [3];
  logic [2:0]              ext_sgn;
  logic [2:0]              ext_sgn_d;
  logic [EQ_W-1:0]         extq [3];
  logic [EQ_W-1:0]         extq_d [3];
  logic                    ext_ovf [3];

  logic signed [D_W-1:0]   d1 [3];
  logic [3*D_W-1:0]        d_dly;
  front_out_t              fo;
  logic [SQ_W-1:0]         sq_quo;
  logic                    sq_ovf;
  logic [1:0]              st_d;
  logic [SQ_W-1:0]         s_r;
  status_t                 st_r;
  logic signed [PROD_W-1:0] prod [3];
  logic [3*PROD_W-1:0]     prod_dly;
  logic [3*POS_W-1:0]      acc;
  logic [3*POS_W-1:0]      acc_dly;
  logic [ROOT_W-1:0]       root;
  logic [ROOT_W-1:0]       root_dly;
  logic [SQ_W+1:0]         sst_dly;

  // advance when the output register is empty or being taken
  assign en       = ~m_tvalid | m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[T_OUT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[T_OUT-2:0], s_tvalid};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      body_mass      <= MASS_W'(65536);
      nrm[0]         <= '0;
      nrm[1]         <= '0;
      nrm[2]         <= NRM_W'(65536);
      tiny_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        CFG_MASS: body_mass      <= cfg_data;
        CFG_NX:   nrm[0]         <= cfg_data[NRM_W-1:0];
        CFG_NY:   nrm[1]         <= cfg_data[NRM_W-1:0];
        CFG_NZ:   nrm[2]         <= cfg_data[NRM_W-1:0];
        CFG_TINY: tiny_threshold <= cfg_data[THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      com[i]     = s_tdata[i*POS_W +: POS_W];
      zmp[i]     = s_tdata[(3+i)*POS_W +: POS_W];
      frc[i]     = s_tdata[(6+i)*POS_W +: POS_W];
      ext[i]     = s_tdata[(9+i)*POS_W +: POS_W];
      ext_mag[i] = ext[i][POS_W-1] ? POS_W'(~ext[i] + 1'b1) : POS_W'(ext[i]);
      ext_sgn[i] = ext[i][POS_W-1];
    end
  end

  czacc_front u_front (
    .clk            (clk),
    .en             (en),
    .com            (com),
    .zmp            (zmp),
    .frc            (frc),
    .body_mass      (body_mass),
    .nrm            (nrm),
    .tiny_threshold (tiny_threshold),
    .d              (d1),
    .fo             (fo)
  );

  // external force over mass, magnitude only; sign travels beside it
  generate
    for (genvar i = 0; i < 3; i++) begin : g_ext
      czacc_div #(.DW(MASS_W), .QW(EQ_W)) u_ediv (
        .clk  (clk),
        .en   (en),
        .rem0 ('0),
        .lo   ({ext_mag[i], {FRAC_BITS{1'b0}}}),
        .den  (eff_mass(body_mass)),
        .quo  (extq[i]),
        .ovf  (ext_ovf[i])
      );
      czacc_dly #(.W(EQ_W), .D(T_ACC - 1 - T_EXTQ)) u_eqd (
        .clk  (clk),
        .en   (en),
        .din  (extq[i]),
        .dout (extq_d[i])
      );
    end
  endgenerate

  czacc_dly #(.W(3), .D(T_ACC - 1)) u_sgnd (
    .clk  (clk),
    .en   (en),
    .din  (ext_sgn),
    .dout (ext_sgn_d)
  );

  czacc_div #(.DW(DEN_W), .QW(SQ_W)) u_sdiv (
    .clk  (clk),
    .en   (en),
    .rem0 (fo.rem0),
    .lo   ('0),
    .den  (fo.den),
    .quo  (sq_quo),
    .ovf  (sq_ovf)
  );

  czacc_dly #(.W(2), .D(SQ_W)) u_std (
    .clk  (clk),
    .en   (en),
    .din  (fo.status),
    .dout (st_d)
  );

  czacc_dly #(.W(3*D_W), .D(T_S - 1)) u_dd (
    .clk  (clk),
    .en   (en),
    .din  ({d1[2], d1[1], d1[0]}),
    .dout (d_dly)
  );

  // zeta squared: zero on a failed check, saturate on quotient overflow
  always_ff @(posedge clk) begin
    if (en) begin
      if (status_t'(st_d) != STAT_OK) begin
        s_r <= '0;
      end else if (sq_ovf) begin
        s_r <= '1;
      end else begin
        s_r <= sq_quo;
      end
      st_r <= status_t'(st_d);
      for (int i = 0; i < 3; i++) begin
        prod[i] <= PROD_W'($signed({1'b0, s_r})) *
                   PROD_W'($signed(d_dly[i*D_W +: D_W]));
      end
    end
  end

  czacc_dly #(.W(3*PROD_W), .D(T_ACC - 1 - T_PROD)) u_pd (
    .clk  (clk),
    .en   (en),
    .din  ({prod[2], prod[1], prod[0]}),
    .dout (prod_dly)
  );

  always_ff @(posedge clk) begin
    logic signed [PROD_W-1:0] pr;
    logic signed [EQ_W:0]     eqs;
    logic signed [ACC_W-1:0]  sum;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pr  = $signed(prod_dly[i*PROD_W +: PROD_W]);
        eqs = ext_sgn_d[i] ? -$signed({1'b0, extq_d[i]}) : $signed({1'b0, extq_d[i]});
        sum = ACC_W'(pr >>> FRAC_BITS) + ACC_W'(eqs);
        if (i == 2) begin
          sum = sum - ACC_W'(GRAV_Q);
        end
        if (sum > ACC_W'(64'sd2147483647)) begin
          acc[i*POS_W +: POS_W] <= {1'b0, {(POS_W-1){1'b1}}};
        end else if (sum < -ACC_W'(64'sd2147483648)) begin
          acc[i*POS_W +: POS_W] <= {1'b1, {(POS_W-1){1'b0}}};
        end else begin
          acc[i*POS_W +: POS_W] <= sum[POS_W-1:0];
        end
      end
    end
  end

  czacc_dly #(.W(3*POS_W), .D(T_OUT - T_ACC)) u_ad (
    .clk  (clk),
    .en   (en),
    .din  (acc),
    .dout (acc_dly)
  );

  czacc_sqrt #(.RW(ROOT_W)) u_sqrt (
    .clk  (clk),
    .en   (en),
    .x    ((2*ROOT_W)'({s_r, {FRAC_BITS{1'b0}}})),
    .root (root)
  );

  czacc_dly #(.W(ROOT_W), .D(T_OUT - T_ROOT)) u_rd (
    .clk  (clk),
    .en   (en),
    .din  (root),
    .dout (root_dly)
  );

  czacc_dly #(.W(SQ_W + 2), .D(T_OUT - T_S)) u_sd (
    .clk  (clk),
    .en   (en),
    .din  ({st_r, s_r}),
    .dout (sst_dly)
  );

  assign m_tdata = {1'b0, root_dly, sst_dly[SQ_W-1:0], acc_dly};
  assign m_tuser = sst_dly[SQ_W+1:SQ_W];

endmodule

// ----- sv/czacc_chk.sv -----
// Port-level checker for the COM-ZMP acceleration core, bound to the top.
// Depends on czacc_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module czacc_chk
  import czacc_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 s_tvalid,
  input logic                 s_tready,
  input logic [12*POS_W-1:0]  s_tdata,
  input logic                 m_tvalid,
  input logic                 m_tready,
  input logic [151:0]         m_tdata,
  input logic [1:0]           m_tuser,
  input logic                 cfg_we,
  input logic [CFG_IDX_W-1:0] cfg_index,
  input logic [MASS_W-1:0]    cfg_data
);

  // hold a stalled word
  `CZ_ASSERT_NEXT(a_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata), "stalled output word changed")
  // input side opens exactly when the output register can move
  `CZ_ASSERT_NOW(a_ready, clk, rst, 1'b1, s_tready == (!m_tvalid || m_tready), "input ready does not follow output stall")
  // a failed check gives zero zeta
  `CZ_ASSERT_NOW(a_zero, clk, rst, m_tvalid && m_tuser != STAT_OK, m_tdata[150:96] == '0, "zeta nonzero on failed check")
  // no word comes out right after reset
  `CZ_ASSERT_NOW(a_rst, clk, rst, $past(rst), !m_tvalid, "output valid right after reset")

endmodule

bind com_zmp_acceleration_core czacc_chk u_chk (.*);
